### design/wcc_pkg.sv
// Shared types and constants for the window congestion control unit.
// No dependencies; imported by wcc_front, wcc_back and the top level.
package wcc_pkg;

   localparam int SEQ_W = 24;
   localparam int CNT_W = 10;

   localparam logic OP_ROUND = 1'b0;
   localparam logic OP_ACK   = 1'b1;

   localparam logic [1:0] PH_SLOW  = 2'd0;
   localparam logic [1:0] PH_AVOID = 2'd1;
   localparam logic [1:0] PH_RECOV = 2'd2;

   localparam logic [1:0] DUP_LIMIT = 2'd3;
   localparam logic [CNT_W-1:0] THRESH_RESET = 10'd64;

   localparam logic CSR_TOTAL  = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [SEQ_W-1:0] ack_number;
   } req_type;

   typedef struct packed {
      logic             send_valid;
      logic [SEQ_W-1:0] start_seq;
      logic [CNT_W-1:0] send_count;
      logic [CNT_W-1:0] window_now;
      logic [CNT_W-1:0] threshold_now;
      logic [1:0]       phase_now;
      logic             finished;
   } rsp_type;

   typedef struct packed {
      logic             opcode;
      logic [SEQ_W-1:0] ack_number;
      logic             over_total;
   } cmd_type;

   typedef struct packed {
      logic [SEQ_W-1:0] total_packets;
      logic             thr_we;
      logic [CNT_W-1:0] thr_value;
   } cfg_type;

endpackage

### design/wcc_fifo.sv
// Small synchronous queue of register words, one push (while not full) and one pop (while not empty) per cycle.
// Stand-alone; used between the front and back and on the result side.
module wcc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("queue pop lost");

   a_push_moves: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue push lost");

endmodule

### design/wcc_front.sv
// Front end: accepts request words, tags the transfer-complete case and queues
// them for the back end. Depends on wcc_pkg and wcc_fifo.
module wcc_front import wcc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   input  logic [SEQ_W-1:0] total_packets,
   output cmd_type          cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);

   cmd_type                 cmd_in;
   logic [$bits(cmd_type)-1:0] cmd_bits;
   logic                    cmd_empty;

   always_comb begin
      cmd_in.opcode     = req_data.opcode;
      cmd_in.ack_number = req_data.ack_number;
      cmd_in.over_total = (req_data.opcode == OP_ACK) &&
                          (req_data.ack_number > total_packets);
   end

   wcc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cmd_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_bits),
      .empty (cmd_empty)
   );

   assign cmd       = cmd_type'(cmd_bits);
   assign cmd_valid = ~cmd_empty;

endmodule

### design/wcc_back.sv
// Back end: holds the congestion state and executes one queued word per cycle while the result queue has room.
// Depends on wcc_pkg.
module wcc_back import wcc_pkg::*; #(
   parameter int MAX_WINDOW = 1023
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   output logic    rsp_push,
   output rsp_type rsp_word,
   input  logic    rsp_full
);

   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int TH_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;
   localparam logic [WIN_W-1:0] WMAX = WIN_W'(MAX_WINDOW);

   logic [SEQ_W-1:0] base_ff, base_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic [TH_W-1:0]  threshold_ff, threshold_in;
   logic [1:0]       dup_ff, dup_in;
   logic [1:0]       phase_ff, phase_in;
   logic             rtx_ff, rtx_in;
   logic [WIN_W-1:0] round_size_ff, round_size_in;
   logic [WIN_W-1:0] acks_ff, acks_in;
   logic             active_ff, active_in;

   logic             exec;
   logic [SEQ_W:0]   left;
   logic [WIN_W-1:0] count;
   logic [WIN_W-1:0] w_ack;
   logic [1:0]       dup_inc;
   logic [WIN_W-1:0] half;
   logic [WIN_W:0]   w_dup_raw;
   logic [WIN_W-1:0] w_dup;
   logic [WIN_W-1:0] acks_inc;

   function automatic logic [WIN_W-1:0] grow(input logic [WIN_W-1:0] w);
      grow = (w >= WMAX) ? WMAX : w + WIN_W'(1);
   endfunction

   assign exec     = cmd_valid & ~rsp_full;
   assign cmd_pop  = exec;
   assign rsp_push = exec;

   always_comb begin
      left = (base_ff <= cfg.total_packets)
           ? ({1'b0, cfg.total_packets} - {1'b0, base_ff} + (SEQ_W+1)'(1))
           : '0;
      count     = ((SEQ_W+1)'(window_ff) < left) ? window_ff : left[WIN_W-1:0];
      dup_inc   = dup_ff + 2'd1;
      half      = window_ff >> 1;
      w_dup_raw = {1'b0, half} + (WIN_W+1)'(3);
      w_dup     = (w_dup_raw > (WIN_W+1)'(MAX_WINDOW)) ? WMAX : w_dup_raw[WIN_W-1:0];
      acks_inc  = acks_ff + WIN_W'(1);
      w_ack     = window_ff;

      base_in       = base_ff;
      window_in     = window_ff;
      threshold_in  = threshold_ff;
      dup_in        = dup_ff;
      phase_in      = phase_ff;
      rtx_in        = rtx_ff;
      round_size_in = round_size_ff;
      acks_in       = acks_ff;
      active_in     = active_ff;

      rsp_word.send_valid = 1'b0;
      rsp_word.start_seq  = '0;
      rsp_word.send_count = '0;
      rsp_word.finished   = 1'b0;

      if (exec) begin
         if (cmd.opcode == OP_ROUND) begin
            if (phase_ff == PH_RECOV && rtx_ff) begin
               rtx_in              = 1'b0;
               active_in           = 1'b0;
               rsp_word.send_valid = 1'b1;
               rsp_word.start_seq  = base_ff;
               rsp_word.send_count = CNT_W'(1);
            end else begin
               acks_in             = '0;
               round_size_in       = count;
               active_in           = (count != '0);
               rsp_word.send_count = CNT_W'(count);
               if (count != '0) begin
                  rsp_word.send_valid = 1'b1;
                  rsp_word.start_seq  = base_ff;
               end
            end
         end else begin
            rsp_word.finished = cmd.over_total;
            if (cmd.ack_number > base_ff) begin
               base_in = cmd.ack_number;
               dup_in  = 2'd0;
               if (phase_ff != PH_AVOID) begin
                  w_ack = grow(window_ff);
               end
               window_in = w_ack;
            end else begin
               dup_in = dup_inc;
            end
            if (cmd.ack_number <= base_ff && dup_inc == DUP_LIMIT) begin
               threshold_in = TH_W'(half);
               window_in    = w_dup;
               dup_in       = 2'd0;
               if (phase_ff != PH_RECOV) begin
                  rtx_in = 1'b1;
               end
               phase_in  = PH_RECOV;
               active_in = 1'b0;
            end else if (active_ff) begin
               acks_in = acks_inc;
               if (acks_inc >= round_size_ff) begin
                  active_in = 1'b0;
                  if (phase_ff == PH_AVOID) begin
                     window_in = grow(w_ack);
                  end else if (TH_W'(w_ack) >= threshold_ff) begin
                     phase_in = PH_AVOID;
                  end
               end
            end
         end
      end

      if (cfg.thr_we) begin
         threshold_in = TH_W'(cfg.thr_value);
      end

      rsp_word.window_now    = CNT_W'(window_in);
      rsp_word.threshold_now = CNT_W'(threshold_in);
      rsp_word.phase_now     = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= SEQ_W'(1);
         window_ff     <= WIN_W'(1);
         threshold_ff  <= TH_W'(THRESH_RESET);
         dup_ff        <= 2'd0;
         phase_ff      <= PH_SLOW;
         rtx_ff        <= 1'b0;
         round_size_ff <= '0;
         acks_ff       <= '0;
         active_ff     <= 1'b0;
      end else begin
         base_ff       <= base_in;
         window_ff     <= window_in;
         threshold_ff  <= threshold_in;
         dup_ff        <= dup_in;
         phase_ff      <= phase_in;
         rtx_ff        <= rtx_in;
         round_size_ff <= round_size_in;
         acks_ff       <= acks_in;
         active_ff     <= active_in;
      end
   end

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      (window_ff != '0) && (window_ff <= WMAX))
      else $error("window out of range");

   a_round_open: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (acks_ff < round_size_ff))
      else $error("round still open after all acks");

   a_rtx_in_recovery: assert property (@(posedge clock) disable iff (reset)
      rtx_ff |-> (phase_ff == PH_RECOV))
      else $error("retransmit pending outside recovery");

endmodule

### design/window_congestion_control_unit.sv
// Sender-side congestion window controller, top level.
// Usage:
//   Request side is a queue input: drive req_data and raise req_push; the word
//   is taken on a clock edge where req_full is low. Opcode round-start asks
//   for a send burst; opcode ack reports the receiver's next expected number.
//   Result side is a queue output: while rsp_empty is low, rsp_data holds the
//   oldest result; raise rsp_pop to take it. Every request yields one result.
//   A request is registered in the command queue and its result in the result queue
//   before it is visible; one request per cycle is sustained while the reader
//   keeps popping results. A two-entry queue sits between
//   front and back and another before the result ports, so a stalled reader
//   fills them and then raises req_full without losing words.
//   csr_we writes register csr_index (0 total packets, 1 initial threshold)
//   in the same edge; write only while no requests are in flight.
//   Synchronous reset clears the queues and loads window 1, base 1, slow start,
//   threshold 64 and total packets 1.
// Depends on wcc_pkg, wcc_fifo, wcc_front and wcc_back.
module window_congestion_control_unit import wcc_pkg::*; #(
   parameter int MAX_WINDOW = 1023
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [SEQ_W-1:0] csr_wdata
);

   logic [SEQ_W-1:0] total_ff, total_in;
   cfg_type          cfg;
   cmd_type          cmd;
   logic             cmd_valid;
   logic             cmd_pop;
   logic             rsp_push;
   rsp_type          rsp_word;
   logic             rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_bits;

   always_comb begin
      total_in = total_ff;
      if (csr_we && csr_index == CSR_TOTAL) begin
         total_in = csr_wdata;
      end
      cfg.total_packets = total_ff;
      cfg.thr_we        = csr_we && (csr_index == CSR_THRESH);
      cfg.thr_value     = csr_wdata[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= SEQ_W'(1);
      end else begin
         total_ff <= total_in;
      end
   end

   wcc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .req_full      (req_full),
      .total_packets (total_ff),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop)
   );

   wcc_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word),
      .rsp_full  (rsp_full)
   );

   wcc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_word),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_bits);

endmodule

### verif/cwnd_check_pkg.sv
// Scoreboard for the window congestion control unit: tracks the sender's window,
// threshold and phase, predicts each result word and checks the words that arrive.
// Depends on wcc_pkg.
`timescale 1ns / 1ps

package cwnd_check_pkg;
   import wcc_pkg::*;

   class cwnd_scoreboard;
      int unsigned win_cap;
      int unsigned total_pkts;
      int unsigned thr_init;
      int unsigned base_seq;
      int unsigned cwnd;
      int unsigned ssthresh;
      int unsigned dups;
      int unsigned burst_len;
      int unsigned acked_in_round;
      logic [1:0]  ph;
      bit          rtx_pending;
      bit          in_round;
      int unsigned peak_cwnd;
      int          errors;
      rsp_type     awaited_updates[$];

      function new(int unsigned cap);
         win_cap        = cap;
         total_pkts     = 1;
         thr_init       = THRESH_RESET;
         base_seq       = 1;
         cwnd           = 1;
         ssthresh       = thr_init;
         dups           = 0;
         ph             = PH_SLOW;
         rtx_pending    = 1'b0;
         burst_len      = 0;
         acked_in_round = 0;
         in_round       = 1'b0;
         peak_cwnd      = 1;
         errors         = 0;
      endfunction

      function void set_reg(logic idx, int unsigned value);
         if (idx == CSR_TOTAL) begin
            total_pkts = value & 32'hFF_FFFF;
         end else begin
            thr_init = value & 32'h3FF;
            ssthresh = thr_init;
         end
      endfunction

      function int unsigned bump(int unsigned w);
         return (w >= win_cap) ? win_cap : w + 1;
      endfunction

      function void close_round();
         in_round = 1'b0;
         if (ph == PH_AVOID) begin
            cwnd = bump(cwnd);
         end else if (cwnd >= ssthresh) begin
            ph = PH_AVOID;
         end
      endfunction

      function void take_ack(int unsigned ack);
         int unsigned half;
         if (ack > base_seq) begin
            base_seq = ack;
            dups = 0;
            if (ph != PH_AVOID) cwnd = bump(cwnd);
         end else begin
            dups = (dups + 1) % 4;
            if (dups == DUP_LIMIT) begin
               half = cwnd / 2;
               ssthresh = half;
               cwnd = (half + 3 > win_cap) ? win_cap : half + 3;
               dups = 0;
               if (ph != PH_RECOV) rtx_pending = 1'b1;
               ph = PH_RECOV;
               in_round = 1'b0;
               return;
            end
         end
         if (in_round) begin
            acked_in_round++;
            if (acked_in_round >= burst_len) close_round();
         end
      endfunction

      function rsp_type take_event(req_type w);
         rsp_type     r;
         int unsigned left;
         r = '0;
         if (w.opcode == OP_ROUND) begin
            if (ph == PH_RECOV && rtx_pending) begin
               rtx_pending  = 1'b0;
               in_round     = 1'b0;
               r.send_valid = 1'b1;
               r.start_seq  = SEQ_W'(base_seq);
               r.send_count = CNT_W'(1);
            end else begin
               left = (base_seq <= total_pkts) ? total_pkts - base_seq + 1 : 0;
               burst_len = (cwnd < left) ? cwnd : left;
               acked_in_round = 0;
               in_round = (burst_len > 0);
               r.send_count = CNT_W'(burst_len);
               if (burst_len > 0) begin
                  r.send_valid = 1'b1;
                  r.start_seq  = SEQ_W'(base_seq);
               end
            end
         end else begin
            r.finished = (w.ack_number > total_pkts);
            take_ack(w.ack_number);
         end
         r.window_now    = CNT_W'(cwnd);
         r.threshold_now = CNT_W'(ssthresh);
         r.phase_now     = ph;
         if (cwnd > peak_cwnd) peak_cwnd = cwnd;
         awaited_updates.insert(awaited_updates.size(), r);
         return r;
      endfunction

      function int pending();
         return awaited_updates.size();
      endfunction

      task report_error(string what, longint unsigned got, longint unsigned want);
         errors++;
         if (errors <= 100)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      endtask

      task check_update(rsp_type got);
         rsp_type want;
         if (awaited_updates.size() == 0) begin
            report_error("result word with no request waiting", got.start_seq, 0);
            return;
         end
         want = awaited_updates.pop_front();
         if (got.send_valid !== want.send_valid)
            report_error("send_valid", got.send_valid, want.send_valid);
         if (got.start_seq !== want.start_seq)
            report_error("start_seq", got.start_seq, want.start_seq);
         if (got.send_count !== want.send_count)
            report_error("send_count", got.send_count, want.send_count);
         if (got.window_now !== want.window_now)
            report_error("window_now", got.window_now, want.window_now);
         if (got.threshold_now !== want.threshold_now)
            report_error("threshold_now", got.threshold_now, want.threshold_now);
         if (got.phase_now !== want.phase_now)
            report_error("phase_now", got.phase_now, want.phase_now);
         if (got.finished !== want.finished)
            report_error("finished", got.finished, want.finished);
      endtask
   endclass

endpackage

### verif/tb_window_congestion_control_unit.sv
// Testbench top for window_congestion_control_unit: directed and random ACK and
// round traffic under several idling modes, checked word by word by cwnd_scoreboard.
// Depends on wcc_pkg, cwnd_check_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_window_congestion_control_unit;
   import wcc_pkg::*;
   import cwnd_check_pkg::*;

   localparam int MAX_WIN     = 1023;
   localparam int CYCLE_LIMIT = 200000;

   logic             clock;
   logic             reset;
   logic             req_push;
   req_type          req_data;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [SEQ_W-1:0] csr_wdata;

   cwnd_scoreboard sb;
   int unsigned    idle_pct;
   int unsigned    stall_pct;
   int             hold_left;
   int             n_sent;
   int             n_checked;
   int             full_stalls;
   int             cycles;
   int unsigned    send_idle_pct [4] = '{0, 58, 0, 28};
   int unsigned    recv_stall_pct[4] = '{0, 0, 58, 28};

   window_congestion_control_unit #(.MAX_WINDOW(MAX_WIN)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            sb.check_update(rsp_data);
            n_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_word(input req_type w, output rsp_type pred);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_full) begin
         full_stalls++;
         @(posedge clock);
      end
      pred = sb.take_event(w);
      n_sent++;
   endtask

   task automatic send_round(output rsp_type pred);
      req_type w;
      w.opcode     = OP_ROUND;
      w.ack_number = SEQ_W'($urandom);
      send_word(w, pred);
   endtask

   task automatic send_ack(input int unsigned ack);
      req_type w;
      rsp_type pred;
      if (ack > 32'hFF_FFFF) ack = 32'hFF_FFFF;
      w.opcode     = OP_ACK;
      w.ack_number = SEQ_W'(ack);
      send_word(w, pred);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int unsigned value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SEQ_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic run_traffic(input int n_items);
      rsp_type     pred;
      int          stop;
      int          n_acks;
      int          kind;
      int unsigned base;
      stop = n_sent + n_items;
      while (n_sent < stop) begin
         send_round(pred);
         if (pred.send_valid)
            n_acks = ((pred.send_count > 16) ? 16 : pred.send_count) + $urandom_range(0, 2);
         else
            n_acks = $urandom_range(0, 3);
         repeat (n_acks) begin
            kind = $urandom_range(99);
            base = sb.base_seq;
            if (kind < 62) begin
               send_ack(base + $urandom_range(1, 3));
            end else if (kind < 76) begin
               send_ack(base);
            end else if (kind < 86) begin
               send_ack($urandom_range(base));
            end else if (kind < 95) begin
               repeat (3) send_ack(base);
            end else begin
               send_ack(base + $urandom_range(4, 40));
            end
         end
      end
   endtask

   initial begin
      rsp_type     pred;
      int unsigned thr;
      sb          = new(MAX_WIN);
      idle_pct    = 0;
      stall_pct   = 0;
      hold_left   = 0;
      n_sent      = 0;
      n_checked   = 0;
      full_stalls = 0;
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_TOTAL;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // one-packet transfer at reset values
      send_round(pred);
      send_round(pred);
      send_ack(0);
      send_ack(2);
      send_round(pred);
      settle();

      write_reg(CSR_TOTAL, 32'hFF_FFFF);
      write_reg(CSR_THRESH, 0);
      send_round(pred);
      send_ack(3);
      repeat (4) send_ack(3);
      send_round(pred);
      send_round(pred);
      repeat (3) send_ack(3);
      send_ack(7);
      send_round(pred);
      settle();

      // grow the window through several rounds
      write_reg(CSR_THRESH, 1023);
      send_round(pred);
      for (int i = 0; i < 48; i++) begin
         if (i % 16 == 15) send_round(pred);
         send_ack(sb.base_seq + 1);
      end
      repeat (3) send_ack(sb.base_seq);
      send_round(pred);

      for (int k = 0; k < 4; k++) begin
         settle();
         idle_pct  = send_idle_pct[k];
         stall_pct = recv_stall_pct[k];
         case (k)
            0:       thr = 0;
            1:       thr = 1023;
            2:       thr = $urandom_range(2, 20);
            default: thr = $urandom_range(0, 1023);
         endcase
         write_reg(CSR_THRESH, thr);
         write_reg(CSR_TOTAL, sb.base_seq + $urandom_range(40, 400));
         if (k == 0) hold_left = 60;
         run_traffic(110);
      end

      settle();
      idle_pct  = 28;
      stall_pct = 28;
      write_reg(CSR_TOTAL, 32'hFF_FFFF);
      write_reg(CSR_THRESH, $urandom_range(0, 1023));
      repeat (6) begin
         send_ack($urandom_range(0, 32'hFF_FFFF));
         send_round(pred);
      end
      send_ack(32'hFF_FFFF);
      send_round(pred);
      repeat (3) send_ack(0);
      send_round(pred);
      settle();

      $display("Covered %0d requests and %0d result words; %0d cycles of input backpressure,",
               n_sent, n_checked, full_stalls);
      $display("peak window %0d, %0d mismatches.", sb.peak_cwnd, sb.errors);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### filelist.f
design/wcc_pkg.sv
design/wcc_fifo.sv
design/wcc_front.sv
design/wcc_back.sv
design/window_congestion_control_unit.sv
verif/cwnd_check_pkg.sv
verif/tb_window_congestion_control_unit.sv
